[hw/rtl/sync_word_correlator_unit_defines.svh]
// Assertion macros shared by the sync word correlator checker.
`ifndef SYNC_WORD_CORRELATOR_UNIT_DEFINES_SVH
`define SYNC_WORD_CORRELATOR_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define SWC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SWC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/swc_pkg.sv]
// Shared types and constants for the sync word correlator.
package swc_pkg;

   // Fixed widths of the item fields.
   localparam int WORD_W       = 64;
   localparam int SAMPLE_W     = 8;
   localparam int SCORE_W      = 7;
   localparam int POSITION_W   = 16;
   localparam int NUM_WORDS    = 4;
   localparam int WORD_INDEX_W = $clog2(NUM_WORDS);
   localparam int CSR_INDEX_W  = 8;

   // Sample index saturates at MAX_ITEMS-1.
   localparam int MAX_ITEMS    = 65536;
   localparam int ITEM_COUNT_W = $clog2(MAX_ITEMS);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WORD_0 = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WORD_1 = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WORD_2 = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WORD_3 = 8'd3;

   // Sync words after reset: LRIT 0 and 180 degrees, HRIT 0 degrees, and a fourth word.
   localparam logic [WORD_W-1:0] RESET_WORDS [NUM_WORDS] = '{
      64'h035d49c24ff2686b,
      64'hfca2b63db00d9794,
      64'h03b10b02f33d2076,
      64'hdafef4fd0cc2df89
   };

   typedef logic [SCORE_W-1:0] score_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [POSITION_W-1:0]   position;
      logic [SCORE_W-1:0]      score;
      logic [WORD_INDEX_W-1:0] word_index;
   } rsp_type;

endpackage

[hw/rtl/swc_match_score.sv]
// Scores one 64-bit window against one sync word as 64 minus the Hamming distance.
module swc_match_score (
   input  logic [swc_pkg::WORD_W-1:0] window,
   input  logic [swc_pkg::WORD_W-1:0] word,
   output swc_pkg::score_type         score
);

   logic [swc_pkg::WORD_W-1:0] diff;
   logic [1:0] lvl1 [32];
   logic [2:0] lvl2 [16];
   logic [3:0] lvl3 [8];
   logic [4:0] lvl4 [4];
   logic [5:0] lvl5 [2];
   logic [6:0] ones;

   assign diff = window ^ word;

   // Balanced adder tree over the differing bits.
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         lvl1[i] = {1'b0, diff[2*i]} + {1'b0, diff[2*i+1]};
      end
      for (int i = 0; i < 16; i++) begin
         lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
      end
      for (int i = 0; i < 8; i++) begin
         lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         lvl5[i] = {1'b0, lvl4[2*i]} + {1'b0, lvl4[2*i+1]};
      end
      ones = {1'b0, lvl5[0]} + {1'b0, lvl5[1]};
   end

   assign score = swc_pkg::SCORE_W'(swc_pkg::WORD_W) - ones;

endmodule

[hw/rtl/sync_word_correlator_unit.sv]
// Top level of the frame sync word correlator.
//
// Usage: soft-bit bytes arrive as items on the req_ channel, one per cycle at
// most. Bit 7 of each sample is shifted into a 64-bit window; once 64 bits
// have arrived, every window is scored against the four sync words held in
// the csr_ registers. The item flagged last produces one result item on the
// rsp_ channel: best position, score and word index, lower index on ties.
// Throughput is one item per cycle while req_ready is high. A result is
// registered once its last item has passed a capture stage, a scoring stage
// with four popcount trees and the best-score update into the result register.
// Reset clears the window, the sample counter, the stored bests and the
// pipeline, and reloads the default sync words. When the receiver stalls,
// items keep flowing until a last item reaches the update stage while a
// result is still waiting; then req_ready drops until the result is taken.
// Configuration writes are taken at any time and belong between buffers.
module sync_word_correlator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  swc_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output swc_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [swc_pkg::WORD_W-1:0]          csr_data
);

   localparam int W   = swc_pkg::WORD_W;
   localparam int N   = swc_pkg::NUM_WORDS;
   localparam int CW  = swc_pkg::ITEM_COUNT_W;
   localparam int PW  = swc_pkg::POSITION_W;
   localparam int IW  = swc_pkg::WORD_INDEX_W;

   logic [W-1:0]  sync_word_ff [N];

   logic [W-1:0]  window_ff, window_in;
   logic [CW-1:0] count_ff, count_in;

   logic          s1_valid_ff;
   logic [W-1:0]  s1_window_ff, s1_window_in;
   logic          s1_scored_ff, s1_scored_in;
   logic [PW-1:0] s1_pos_ff, s1_pos_in;
   logic          s1_last_ff;

   swc_pkg::score_type s1_score [N];

   logic               s2_valid_ff;
   swc_pkg::score_type s2_score_ff [N];
   logic               s2_scored_ff;
   logic [PW-1:0]      s2_pos_ff;
   logic               s2_last_ff;

   swc_pkg::score_type best_score_ff [N];
   swc_pkg::score_type best_score_in [N];
   logic [PW-1:0]      best_pos_ff [N];
   logic [PW-1:0]      best_pos_in [N];
   swc_pkg::score_type new_score [N];
   logic [PW-1:0]      new_pos [N];
   logic [IW-1:0]      sel;

   logic             rsp_valid_ff, rsp_valid_in;
   swc_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic advance;
   logic accept;
   logic fire;

   // The pipeline holds only when a last item meets a result still waiting.
   assign advance   = !(s2_valid_ff && s2_last_ff && rsp_valid_ff && !rsp_ready);
   assign accept    = req_valid && advance;
   assign fire      = advance && s2_valid_ff;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   // Configuration registers; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            sync_word_ff[k] <= swc_pkg::RESET_WORDS[k];
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            swc_pkg::CSR_SYNC_WORD_0: sync_word_ff[0] <= csr_data;
            swc_pkg::CSR_SYNC_WORD_1: sync_word_ff[1] <= csr_data;
            swc_pkg::CSR_SYNC_WORD_2: sync_word_ff[2] <= csr_data;
            swc_pkg::CSR_SYNC_WORD_3: sync_word_ff[3] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Window shift and saturating sample count; both restart after a last item.
   always_comb begin
      s1_window_in = {window_ff[W-2:0], req_payload.sample[swc_pkg::SAMPLE_W-1]};
      s1_scored_in = (count_ff >= CW'(W - 1));
      s1_pos_in    = PW'(count_ff - CW'(W - 1));
      window_in    = window_ff;
      count_in     = count_ff;
      if (accept) begin
         if (req_payload.last) begin
            window_in = '0;
            count_in  = '0;
         end else begin
            window_in = s1_window_in;
            if (count_ff != CW'(swc_pkg::MAX_ITEMS - 1)) begin
               count_in = count_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff  <= '0;
      end else begin
         window_ff <= window_in;
         count_ff  <= count_in;
      end
   end

   // Capture stage and scoring stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_window_ff <= s1_window_in;
         s1_scored_ff <= s1_scored_in;
         s1_pos_ff    <= s1_pos_in;
         s1_last_ff   <= req_payload.last;
         s2_scored_ff <= s1_scored_ff;
         s2_pos_ff    <= s1_pos_ff;
         s2_last_ff   <= s1_last_ff;
         for (int k = 0; k < N; k++) begin
            s2_score_ff[k] <= s1_score[k];
         end
      end
   end

   // One scorer for each sync word.
   for (genvar g = 0; g < N; g++) begin : g_score
      swc_match_score u_score (
         .window (s1_window_ff),
         .word   (sync_word_ff[g]),
         .score  (s1_score[g])
      );
   end

   // Best-score update, selection of the winning word and result capture.
   always_comb begin
      sel = '0;
      for (int k = 0; k < N; k++) begin
         new_score[k] = best_score_ff[k];
         new_pos[k]   = best_pos_ff[k];
         if (s2_scored_ff && (s2_score_ff[k] > best_score_ff[k])) begin
            new_score[k] = s2_score_ff[k];
            new_pos[k]   = s2_pos_ff;
         end
      end
      for (int k = 1; k < N; k++) begin
         if (new_score[k] > new_score[sel]) begin
            sel = IW'(k);
         end
      end

      for (int k = 0; k < N; k++) begin
         best_score_in[k] = best_score_ff[k];
         best_pos_in[k]   = best_pos_ff[k];
         if (fire) begin
            best_score_in[k] = s2_last_ff ? '0 : new_score[k];
            best_pos_in[k]   = s2_last_ff ? '0 : new_pos[k];
         end
      end

      rsp_payload_in.position   = new_pos[sel];
      rsp_payload_in.score      = new_score[sel];
      rsp_payload_in.word_index = sel;

      rsp_valid_in = rsp_valid_ff;
      if (fire && s2_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < N; k++) begin
            best_score_ff[k] <= '0;
            best_pos_ff[k]   <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < N; k++) begin
            best_score_ff[k] <= best_score_in[k];
            best_pos_ff[k]   <= best_pos_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && s2_last_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[hw/rtl/swc_checker.sv]
// Port-level checker for the sync word correlator, bound to the top level.
`include "sync_word_correlator_unit_defines.svh"

module swc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input swc_pkg::rsp_type rsp_payload
);

   // A stalled result item holds its value.
   `SWC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled result item changed")

   // Reset leaves no result pending.
   `SWC_ASSERT_ALWAYS(a_rsp_reset, clock, $past(reset) |-> !rsp_valid, "result item pending after reset")

   // A score never exceeds the window length.
   `SWC_ASSERT(a_score_range, clock, reset, rsp_valid |-> rsp_payload.score <= 7'd64, "score out of range")

   // A zero score means no window ever matched, so the result is all zero.
   `SWC_ASSERT(a_zero_score, clock, reset, rsp_valid && rsp_payload.score == '0 |-> rsp_payload.position == '0 && rsp_payload.word_index == '0, "zero score with nonzero position or index")

endmodule

bind sync_word_correlator_unit swc_checker u_swc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

[tb/tb_sync_word_correlator_unit.sv]
// Self-checking testbench for the frame sync word correlator: directed rows, random buffers, stalls.
`timescale 1ns / 1ps

module tb_sync_word_correlator_unit;

   // Local names for the shared widths, codes and types.
   localparam int WORD_W       = swc_pkg::WORD_W;
   localparam int SAMPLE_W     = swc_pkg::SAMPLE_W;
   localparam int POSITION_W   = swc_pkg::POSITION_W;
   localparam int NUM_WORDS    = swc_pkg::NUM_WORDS;
   localparam int WORD_INDEX_W = swc_pkg::WORD_INDEX_W;
   localparam int CSR_INDEX_W  = swc_pkg::CSR_INDEX_W;
   localparam int MAX_ITEMS    = swc_pkg::MAX_ITEMS;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WORD_0 = swc_pkg::CSR_SYNC_WORD_0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WORD_1 = swc_pkg::CSR_SYNC_WORD_1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WORD_2 = swc_pkg::CSR_SYNC_WORD_2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WORD_3 = swc_pkg::CSR_SYNC_WORD_3;
   localparam logic [WORD_W-1:0] RESET_WORDS [NUM_WORDS] = swc_pkg::RESET_WORDS;

   typedef swc_pkg::score_type score_type;
   typedef swc_pkg::req_type   req_type;
   typedef swc_pkg::rsp_type   rsp_type;

   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;
   localparam int IDLE_PCT      = 30;
   localparam int RANDOM_ITEMS  = 300;
   localparam int RANDOM_REPORTS = 12;
   localparam int NO_EMBED      = -1;

   localparam logic [CSR_INDEX_W-1:0] WORD_INDEXES [NUM_WORDS] = '{
      CSR_SYNC_WORD_0, CSR_SYNC_WORD_1, CSR_SYNC_WORD_2, CSR_SYNC_WORD_3
   };
   // Indexes past the last sync word; writes to them must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_BEYOND_WORDS = CSR_INDEX_W'(CSR_SYNC_WORD_3 + 1);
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_TOP    = '1;

   // One directed row: a run of equal samples, optionally closing a buffer.
   typedef struct {
      int                  phase;
      logic [SAMPLE_W-1:0] sample;
      int                  run;
      bit                  ends_buffer;
      bit                  from_table;
      rsp_type             want;
   } script_row_type;

   // How the expected report of a last item is obtained.
   typedef struct {
      bit      from_table;
      rsp_type want;
   } last_tag_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]      csr_data = '0;

   // Predictor state: sync words, bit window, sample index, best per word.
   logic [WORD_W-1:0]     live_words [NUM_WORDS] = RESET_WORDS;
   logic [WORD_W-1:0]     window_bits = '0;
   logic [POSITION_W-1:0] sample_count = '0;
   score_type             top_score [NUM_WORDS] = '{default: '0};
   logic [POSITION_W-1:0] top_start [NUM_WORDS] = '{default: '0};

   rsp_type      expected_reports [$];
   last_tag_type last_tags [$];
   int        error_count = 0;
   int        items_sent = 0;
   int        quiet_cycles = 0;
   int        req_idle_pct = IDLE_PCT;
   int        rsp_idle_pct = IDLE_PCT;
   int        hold_cycles_req = 0;

   localparam rsp_type NO_WINDOW = {16'd0, 7'd0, 2'd0};

   // Word settings for the directed phases 1 to 3; phase 0 runs on reset words.
   logic [WORD_W-1:0] directed_words [3][NUM_WORDS] = '{
      '{64'h0, 64'h0, 64'h0, 64'h0},
      '{'1, '1, '1, '1},
      '{64'h0, '1, 64'h0000_0000_ffff_ffff, '1}
   };

   script_row_type directed_rows [15] = '{
      '{0, 8'h00, 1, 1, 1, NO_WINDOW},
      '{0, 8'hff, 1, 1, 1, NO_WINDOW},
      '{0, 8'h7f, 30, 0, 0, '0},
      '{0, 8'h80, 33, 1, 1, NO_WINDOW},
      '{0, 8'h80, 64, 1, 0, '0},
      '{0, 8'h01, 100, 1, 0, '0},
      '{1, 8'hff, 64, 1, 1, NO_WINDOW},
      '{1, 8'h00, 70, 1, 1, {16'd0, 7'd64, 2'd0}},
      '{2, 8'h80, 64, 1, 1, {16'd0, 7'd64, 2'd0}},
      '{2, 8'h7f, 10, 0, 0, '0},
      '{2, 8'hff, 64, 1, 1, {16'd10, 7'd64, 2'd0}},
      '{3, 8'hff, 64, 1, 1, {16'd0, 7'd64, 2'd1}},
      '{3, 8'h00, 64, 1, 1, {16'd0, 7'd64, 2'd0}},
      '{3, 8'h00, 32, 0, 0, '0},
      '{3, 8'h80, 32, 1, 1, {16'd0, 7'd64, 2'd2}}
   };

   sync_word_correlator_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shift one hard bit in, update the per-word bests, and on the last item
   // produce the sync report and clear the search.
   function automatic bit correlate_sample(input req_type item, output rsp_type report);
      int score;
      int best;
      best = 0;
      report = '0;
      window_bits = {window_bits[WORD_W-2:0], item.sample[SAMPLE_W-1]};
      if (sample_count >= POSITION_W'(WORD_W - 1)) begin
         for (int k = 0; k < NUM_WORDS; k++) begin
            score = WORD_W - $countones(window_bits ^ live_words[k]);
            if (score > top_score[k]) begin
               top_score[k] = score_type'(score);
               top_start[k] = sample_count - POSITION_W'(WORD_W - 1);
            end
         end
      end
      if (sample_count != POSITION_W'(MAX_ITEMS - 1)) begin
         sample_count++;
      end
      if (!item.last) begin
         return 1'b0;
      end
      // Strictly greater, so ties stay with the lower word index.
      for (int k = 1; k < NUM_WORDS; k++) begin
         if (top_score[k] > top_score[best]) begin
            best = k;
         end
      end
      report.position = top_start[best];
      report.score = top_score[best];
      report.word_index = WORD_INDEX_W'(best);
      window_bits = '0;
      sample_count = '0;
      top_score = '{default: '0};
      top_start = '{default: '0};
      return 1'b1;
   endfunction

   // Follow accepted items through the predictor and check every report.
   always @(posedge clock) begin : track_reports
      rsp_type      predicted;
      rsp_type      want;
      last_tag_type tag;
      if (!reset) begin
         if (csr_valid && csr_ready && csr_index <= CSR_SYNC_WORD_3) begin
            live_words[csr_index[WORD_INDEX_W-1:0]] = csr_data;
         end
         if (req_valid && req_ready) begin
            if (correlate_sample(req_payload, predicted)) begin
               tag = last_tags.pop_front();
               expected_reports.push_back(tag.from_table ? tag.want : predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("report item with no expectation: %p", rsp_payload);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_payload.position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position,
                         rsp_payload.position);
                  error_count++;
               end
               if (rsp_payload.score !== want.score) begin
                  $error("score: expected %0d, got %0d", want.score, rsp_payload.score);
                  error_count++;
               end
               if (rsp_payload.word_index !== want.word_index) begin
                  $error("word_index: expected %0d, got %0d", want.word_index,
                         rsp_payload.word_index);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles in which no channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result receiver: random back-pressure, plus long hold-offs on request.
   initial begin : result_receiver
      int hold;
      forever begin
         @(posedge clock);
         if (hold_cycles_req != 0) begin
            hold = hold_cycles_req;
            hold_cycles_req = 0;
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Offer one item, with a random gap first, and wait until it is taken.
   task automatic send_sample(input req_type item, input bit from_table, input rsp_type want);
      last_tag_type tag;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      if (item.last) begin
         tag.from_table = from_table;
         tag.want = want;
         last_tags.push_back(tag);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      items_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   // Send one buffer; a 64-bit pattern is placed at offset unless NO_EMBED.
   task automatic send_buffer(input int length, input int offset,
                              input logic [WORD_W-1:0] pattern);
      req_type item;
      logic    hard;
      for (int i = 0; i < length; i++) begin
         if (offset != NO_EMBED && i >= offset && i < offset + WORD_W) begin
            hard = pattern[WORD_W - 1 - (i - offset)];
         end else begin
            hard = 1'($urandom_range(1));
         end
         item.sample = {hard, 7'($urandom_range(127))};
         item.last = (i == length - 1);
         send_sample(item, 1'b0, '0);
      end
   endtask

   // Mostly buffers carrying a noisy sync word; some truncated, some pure noise.
   task automatic send_random_buffer();
      int                shape;
      int                length;
      logic [WORD_W-1:0] pattern;
      shape = $urandom_range(99);
      pattern = live_words[$urandom_range(NUM_WORDS - 1)];
      repeat ($urandom_range(3)) pattern[$urandom_range(WORD_W - 1)] ^= 1'b1;
      if (shape < 70) begin
         length = $urandom_range(WORD_W, 120);
         send_buffer(length, $urandom_range(length - WORD_W), pattern);
      end else if (shape < 85) begin
         send_buffer($urandom_range(1, WORD_W - 1), 0, pattern);
      end else begin
         send_buffer($urandom_range(WORD_W, 160), NO_EMBED, '0);
      end
   endtask

   // Stop offering items and wait until every expected report has come.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0 || last_tags.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four sync words, then one write to an unused index.
   task automatic load_sync_words(input logic [WORD_W-1:0] words [NUM_WORDS]);
      for (int k = 0; k < NUM_WORDS; k++) begin
         csr_valid <= 1'b1;
         csr_index <= WORD_INDEXES[k];
         csr_data <= words[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b1;
      csr_index <= $urandom_range(1) ? CSR_BEYOND_WORDS : CSR_INDEX_TOP;
      csr_data <= {$urandom, $urandom};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int                phase_now;
      int                phase_no;
      int                items_start;
      int                buffers_random;
      logic [WORD_W-1:0] next_words [NUM_WORDS];
      req_type           item;
      phase_now = 0;
      phase_no = 0;
      buffers_random = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed rows, switching the sync words between phases.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].phase != phase_now) begin
            settle();
            phase_now = directed_rows[r].phase;
            load_sync_words(directed_words[phase_now - 1]);
         end
         for (int i = 0; i < directed_rows[r].run; i++) begin
            item.sample = directed_rows[r].sample;
            item.last = directed_rows[r].ends_buffer && (i == directed_rows[r].run - 1);
            send_sample(item, directed_rows[r].from_table, directed_rows[r].want);
         end
      end
      settle();

      // Random phases: new sync words, then a batch of buffers.
      items_start = items_sent;
      while (items_sent - items_start < RANDOM_ITEMS || buffers_random < RANDOM_REPORTS ||
             phase_no < 4) begin
         phase_no++;
         case ($urandom_range(3))
            0: next_words = RESET_WORDS;
            1: foreach (next_words[k]) next_words[k] = $urandom_range(1) ? '1 : '0;
            default: foreach (next_words[k]) next_words[k] = {$urandom, $urandom};
         endcase
         load_sync_words(next_words);
         req_idle_pct = (phase_no % 4 == 2) ? 0 : IDLE_PCT;
         rsp_idle_pct = req_idle_pct;
         if (phase_no == 3) begin
            // Receiver holds off while short buffers keep coming.
            req_idle_pct = 0;
            hold_cycles_req = HOLD_CYCLES;
            repeat (10) begin
               send_buffer($urandom_range(1, 8), NO_EMBED, '0);
               buffers_random++;
            end
         end else begin
            repeat ($urandom_range(1, 2)) begin
               send_random_buffer();
               buffers_random++;
            end
         end
         settle();
      end

      while (expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
